### hdl/udt_pkg.sv
// Shared types and constants for the Unix seconds to UTC date and time converter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package udt_pkg;

    // Pipeline shape: stage 0 registers the request, stage 10 is the output register.
    localparam int NUM_STAGES = 11;
    localparam int STG_IN     = 0;
    localparam int STG_DAYS   = 1;
    localparam int STG_SPLIT  = 2;
    localparam int STG_LAST   = NUM_STAGES - 1;

    // Field widths.
    localparam int SECS_W  = 38;
    localparam int DAYS_W  = 22;
    localparam int JDN_W   = 23;
    localparam int SOD_W   = 17;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Seconds to days: secs / 86400 = (secs >> 7) / 675, done as a reciprocal multiply.
    localparam int              DAY_PRE_SHIFT = 7;
    localparam int              DAY_SHIFT     = 41;
    localparam logic [31:0]     DAY_RECIP     = 32'd3257812231;
    localparam logic [16:0]     SECS_PER_DAY  = 17'd86400;

    // Epoch Julian day number plus the offset the inverse algorithm starts from.
    localparam logic [JDN_W-1:0] JDN_BIAS = 23'd2472632;

    // Day number to 400-year eras.
    localparam int              ERA_SHIFT    = 41;
    localparam logic [23:0]     ERA_RECIP    = 24'd15051803;
    localparam logic [17:0]     DAYS_PER_ERA = 18'd146097;

    // Centuries, four-year cycles and years within an era.
    localparam logic [17:0]     DAYS_PER_CENT = 18'd36524;
    localparam int              QUAD_SHIFT    = 27;
    localparam logic [16:0]     QUAD_RECIP    = 17'd91868;
    localparam logic [15:0]     DAYS_PER_QUAD = 16'd1461;
    localparam logic [10:0]     DAYS_PER_YEAR = 11'd365;

    // Month from day of a March-based year: (5 * da + 308) / 153.
    localparam int              MON_SHIFT  = 20;
    localparam logic [12:0]     MON_RECIP  = 13'd6854;
    localparam logic [11:0]     MON_OFFSET = 12'd308;
    localparam logic [3:0]      MON_WRAP   = 4'd12;
    localparam logic [YEAR_W-1:0] YEAR_BIAS = 14'd4800;

    // Time of day.
    localparam int              HOUR_SHIFT    = 29;
    localparam logic [17:0]     HOUR_RECIP    = 18'd149131;
    localparam logic [16:0]     SECS_PER_HOUR = 17'd3600;
    localparam int              MIN_SHIFT     = 18;
    localparam logic [12:0]     MIN_RECIP     = 13'd4370;
    localparam logic [11:0]     SECS_PER_MIN  = 12'd60;

    // Per-stage load enables handed from the top level to the datapath modules.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } udt_ctl_t;

    // Time of day as it travels through the delay stages.
    typedef struct packed {
        logic [SEC_W-1:0]  second;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
    } udt_time_t;

endpackage

`default_nettype wire

### hdl/udt_split.sv
// Front end: registers the request and splits seconds into a day number and seconds of day.
// Depends on udt_pkg.
`default_nettype none

module udt_split (
    input  wire logic                          aclk,
    input  wire udt_pkg::udt_ctl_t             ctl,
    input  wire logic [udt_pkg::SECS_W-1:0]    epoch_seconds,
    output logic      [udt_pkg::JDN_W-1:0]     jdn,
    output logic      [udt_pkg::SOD_W-1:0]     sod
);

    logic [udt_pkg::SECS_W-1:0] secs0_reg;
    logic [udt_pkg::DAYS_W-1:0] days1_reg;
    logic [udt_pkg::SOD_W-1:0]  secs_lo1_reg;
    logic [udt_pkg::JDN_W-1:0]  jdn2_reg;
    logic [udt_pkg::SOD_W-1:0]  sod2_reg;

    logic [62:0] day_prod;
    logic [38:0] day_secs;

    // Days = floor((secs >> 7) / 675) by multiplying with a rounded-up reciprocal.
    assign day_prod = 63'(secs0_reg[udt_pkg::SECS_W-1:udt_pkg::DAY_PRE_SHIFT])
                    * 63'(udt_pkg::DAY_RECIP);

    // Seconds consumed by the whole days; only the low bits matter for the remainder.
    assign day_secs = 39'(days1_reg) * 39'(udt_pkg::SECS_PER_DAY);

    always_ff @(posedge aclk) begin
        if (ctl.load[udt_pkg::STG_IN]) begin
            secs0_reg <= epoch_seconds;
        end
        if (ctl.load[udt_pkg::STG_DAYS]) begin
            days1_reg    <= day_prod[udt_pkg::DAY_SHIFT+udt_pkg::DAYS_W-1:udt_pkg::DAY_SHIFT];
            secs_lo1_reg <= secs0_reg[udt_pkg::SOD_W-1:0];
        end
        if (ctl.load[udt_pkg::STG_SPLIT]) begin
            jdn2_reg <= udt_pkg::JDN_W'(days1_reg) + udt_pkg::JDN_BIAS;
            sod2_reg <= secs_lo1_reg - day_secs[udt_pkg::SOD_W-1:0];
        end
    end

    assign jdn = jdn2_reg;
    assign sod = sod2_reg;

endmodule

`default_nettype wire

### hdl/udt_clock.sv
// Time-of-day path: hour, minute and second from seconds of day, delayed to the output stage.
// Depends on udt_pkg.
`default_nettype none

module udt_clock (
    input  wire logic                        aclk,
    input  wire udt_pkg::udt_ctl_t           ctl,
    input  wire logic [udt_pkg::SOD_W-1:0]   sod,
    output logic      [udt_pkg::HOUR_W-1:0]  hour,
    output logic      [udt_pkg::MIN_W-1:0]   minute,
    output logic      [udt_pkg::SEC_W-1:0]   second
);

    logic [udt_pkg::SOD_W-1:0]  sod3_reg;
    logic [udt_pkg::HOUR_W-1:0] hour3_reg;
    logic [udt_pkg::HOUR_W-1:0] hour4_reg;
    logic [11:0]                rem4_reg;
    logic [udt_pkg::HOUR_W-1:0] hour5_reg;
    logic [11:0]                rem5_reg;
    logic [udt_pkg::MIN_W-1:0]  min5_reg;
    udt_pkg::udt_time_t         time6_reg;
    udt_pkg::udt_time_t         dly7_reg;
    udt_pkg::udt_time_t         dly8_reg;
    udt_pkg::udt_time_t         dly9_reg;
    udt_pkg::udt_time_t         out10_reg;

    logic [34:0] hour_prod;
    logic [16:0] hour_secs;
    logic [24:0] min_prod;
    logic [11:0] min_secs;

    // Reciprocal multiplies stand in for the divisions by 3600 and 60.
    assign hour_prod = 35'(sod) * 35'(udt_pkg::HOUR_RECIP);
    assign hour_secs = 17'(hour3_reg) * udt_pkg::SECS_PER_HOUR;
    assign min_prod  = 25'(rem4_reg) * 25'(udt_pkg::MIN_RECIP);
    assign min_secs  = 12'(min5_reg) * udt_pkg::SECS_PER_MIN;

    always_ff @(posedge aclk) begin
        // Hour and the seconds within it.
        if (ctl.load[3]) begin
            hour3_reg <= hour_prod[udt_pkg::HOUR_SHIFT+udt_pkg::HOUR_W-1:udt_pkg::HOUR_SHIFT];
            sod3_reg  <= sod;
        end
        if (ctl.load[4]) begin
            hour4_reg <= hour3_reg;
            rem4_reg  <= sod3_reg[11:0] - hour_secs[11:0];
        end
        // Minute and second.
        if (ctl.load[5]) begin
            hour5_reg <= hour4_reg;
            rem5_reg  <= rem4_reg;
            min5_reg  <= min_prod[udt_pkg::MIN_SHIFT+udt_pkg::MIN_W-1:udt_pkg::MIN_SHIFT];
        end
        if (ctl.load[6]) begin
            time6_reg.hour   <= hour5_reg;
            time6_reg.minute <= min5_reg;
            time6_reg.second <= rem5_reg[udt_pkg::SEC_W-1:0] - min_secs[udt_pkg::SEC_W-1:0];
        end
        // Delay line that keeps the time aligned with the date path.
        if (ctl.load[7]) begin
            dly7_reg <= time6_reg;
        end
        if (ctl.load[8]) begin
            dly8_reg <= dly7_reg;
        end
        if (ctl.load[9]) begin
            dly9_reg <= dly8_reg;
        end
        if (ctl.load[udt_pkg::STG_LAST]) begin
            out10_reg <= dly9_reg;
        end
    end

    assign hour   = out10_reg.hour;
    assign minute = out10_reg.minute;
    assign second = out10_reg.second;

endmodule

`default_nettype wire

### hdl/udt_date.sv
// Calendar path: converts a Julian day number to a date through 400-year eras, centuries, four-year cycles and years.
// Depends on udt_pkg.
`default_nettype none

module udt_date (
    input  wire logic                         aclk,
    input  wire udt_pkg::udt_ctl_t            ctl,
    input  wire logic [udt_pkg::JDN_W-1:0]    jdn,
    output logic      [udt_pkg::YEAR_W-1:0]   year,
    output logic      [udt_pkg::MONTH_W-1:0]  month,
    output logic      [udt_pkg::DOM_W-1:0]    day_of_month
);

    // Day of the March-based year on which a month starts, plus 122, indexed by month + 2.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd2:    start = 9'd122;
            4'd3:    start = 9'd153;
            4'd4:    start = 9'd183;
            4'd5:    start = 9'd214;
            4'd6:    start = 9'd244;
            4'd7:    start = 9'd275;
            4'd8:    start = 9'd306;
            4'd9:    start = 9'd336;
            4'd10:   start = 9'd367;
            4'd11:   start = 9'd397;
            4'd12:   start = 9'd428;
            4'd13:   start = 9'd459;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

    logic [udt_pkg::JDN_W-1:0]  j3_reg;
    logic [5:0]                 g3_reg;
    logic [5:0]                 g4_reg;
    logic [17:0]                dg4_reg;
    logic [5:0]                 g5_reg;
    logic [1:0]                 c5_reg;
    logic [15:0]                dc5_reg;
    logic [5:0]                 g6_reg;
    logic [1:0]                 c6_reg;
    logic [15:0]                dc6_reg;
    logic [4:0]                 b6_reg;
    logic [5:0]                 g7_reg;
    logic [1:0]                 c7_reg;
    logic [4:0]                 b7_reg;
    logic [10:0]                db7_reg;
    logic [8:0]                 da8_reg;
    logic [udt_pkg::YEAR_W-1:0] ybase8_reg;
    logic [8:0]                 da9_reg;
    logic [udt_pkg::YEAR_W-1:0] ybase9_reg;
    logic [3:0]                 mp9_reg;
    logic [udt_pkg::YEAR_W-1:0] year10_reg;
    logic [udt_pkg::MONTH_W-1:0] month10_reg;
    logic [udt_pkg::DOM_W-1:0]  dom10_reg;

    logic [46:0] era_prod;
    logic [23:0] era_days;
    logic [1:0]  cent;
    logic [17:0] cent_days;
    logic [32:0] quad_prod;
    logic [15:0] quad_days;
    logic [1:0]  yr;
    logic [10:0] yr_days;
    logic [udt_pkg::YEAR_W-1:0] ybase;
    logic [11:0] mon_arg;
    logic [24:0] mon_prod;
    logic        wrap;
    logic [9:0]  dom_sum;

    // Era index by reciprocal multiply, then the day within the era.
    assign era_prod = 47'(jdn) * 47'(udt_pkg::ERA_RECIP);
    assign era_days = 24'(g3_reg) * 24'(udt_pkg::DAYS_PER_ERA);

    // Century within the era: the fourth boundary folds back onto the last century.
    assign cent = 2'(dg4_reg >= udt_pkg::DAYS_PER_CENT)
                + 2'(dg4_reg >= 18'(2 * udt_pkg::DAYS_PER_CENT))
                + 2'(dg4_reg >= 18'(3 * udt_pkg::DAYS_PER_CENT));
    assign cent_days = 18'(cent) * udt_pkg::DAYS_PER_CENT;

    // Four-year cycle within the century.
    assign quad_prod = 33'(dc5_reg) * 33'(udt_pkg::QUAD_RECIP);
    assign quad_days = 16'(b6_reg) * udt_pkg::DAYS_PER_QUAD;

    // Year within the cycle, again folding the fourth boundary.
    assign yr = 2'(db7_reg >= udt_pkg::DAYS_PER_YEAR)
              + 2'(db7_reg >= 11'(2 * udt_pkg::DAYS_PER_YEAR))
              + 2'(db7_reg >= 11'(3 * udt_pkg::DAYS_PER_YEAR));
    assign yr_days = 11'(yr) * udt_pkg::DAYS_PER_YEAR;
    assign ybase   = udt_pkg::YEAR_W'(g7_reg) * 14'd400 + udt_pkg::YEAR_W'(c7_reg) * 14'd100
                   + udt_pkg::YEAR_W'({b7_reg, 2'b00}) + udt_pkg::YEAR_W'(yr);

    // Month counted from March, plus two.
    assign mon_arg  = {1'b0, da8_reg, 2'b00} + 12'(da8_reg) + udt_pkg::MON_OFFSET;
    assign mon_prod = 25'(mon_arg) * 25'(udt_pkg::MON_RECIP);

    // January and February belong to the next calendar year.
    assign wrap    = (mp9_reg >= udt_pkg::MON_WRAP);
    assign dom_sum = 10'(da9_reg) + 10'd123 - 10'(month_start(mp9_reg));

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            j3_reg <= jdn;
            g3_reg <= era_prod[udt_pkg::ERA_SHIFT+5:udt_pkg::ERA_SHIFT];
        end
        if (ctl.load[4]) begin
            g4_reg  <= g3_reg;
            dg4_reg <= j3_reg[17:0] - era_days[17:0];
        end
        if (ctl.load[5]) begin
            g5_reg  <= g4_reg;
            c5_reg  <= cent;
            dc5_reg <= 16'(dg4_reg - cent_days);
        end
        if (ctl.load[6]) begin
            g6_reg  <= g5_reg;
            c6_reg  <= c5_reg;
            dc6_reg <= dc5_reg;
            b6_reg  <= quad_prod[udt_pkg::QUAD_SHIFT+4:udt_pkg::QUAD_SHIFT];
        end
        if (ctl.load[7]) begin
            g7_reg  <= g6_reg;
            c7_reg  <= c6_reg;
            b7_reg  <= b6_reg;
            db7_reg <= dc6_reg[10:0] - quad_days[10:0];
        end
        if (ctl.load[8]) begin
            da8_reg    <= 9'(db7_reg - yr_days);
            ybase8_reg <= ybase;
        end
        if (ctl.load[9]) begin
            da9_reg    <= da8_reg;
            ybase9_reg <= ybase8_reg;
            mp9_reg    <= mon_prod[udt_pkg::MON_SHIFT+3:udt_pkg::MON_SHIFT];
        end
        // Output stage: calendar month, day and year.
        if (ctl.load[udt_pkg::STG_LAST]) begin
            month10_reg <= wrap ? (mp9_reg - 4'd11) : (mp9_reg + 4'd1);
            dom10_reg   <= dom_sum[udt_pkg::DOM_W-1:0];
            year10_reg  <= ybase9_reg - udt_pkg::YEAR_BIAS + udt_pkg::YEAR_W'(wrap);
        end
    end

    assign year         = year10_reg;
    assign month        = month10_reg;
    assign day_of_month = dom10_reg;

endmodule

`default_nettype wire

### hdl/unix_seconds_to_datetime.sv
// Unix seconds to UTC date and time of day, an eleven-stage pipeline.
// Throughput: one request per cycle while the output is not stalled (m_tready high).
// A stage loads whenever it is empty or its successor moves, so bubbles close up.
// Reset (aresetn low, synchronous) clears the stage valid bits only.
// Depends on udt_pkg, udt_split, udt_date and udt_clock.
`default_nettype none

module unix_seconds_to_datetime (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata: epoch_seconds[37:0], zero padding [39:38]
    input  wire logic [udt_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata: year[13:0], month[17:14], day_of_month[22:18], hour[27:23],
    //          minute[33:28], second[39:34]
    output logic      [udt_pkg::M_TDATA_W-1:0]    m_tdata
);

    logic [udt_pkg::NUM_STAGES-1:0] valid_reg;
    logic [udt_pkg::NUM_STAGES-1:0] valid_next;
    logic [udt_pkg::NUM_STAGES:0]   adv;
    udt_pkg::udt_ctl_t              ctl;

    logic [udt_pkg::JDN_W-1:0]   jdn;
    logic [udt_pkg::SOD_W-1:0]   sod;
    logic [udt_pkg::YEAR_W-1:0]  year;
    logic [udt_pkg::MONTH_W-1:0] month;
    logic [udt_pkg::DOM_W-1:0]   day_of_month;
    logic [udt_pkg::HOUR_W-1:0]  hour;
    logic [udt_pkg::MIN_W-1:0]   minute;
    logic [udt_pkg::SEC_W-1:0]   second;

    // A stage may load when it is empty or its contents move on.
    always_comb begin
        adv[udt_pkg::NUM_STAGES] = m_tready;
        for (int k = udt_pkg::NUM_STAGES - 1; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    // Valid bits follow the data through the stages.
    always_comb begin
        valid_next    = valid_reg;
        if (adv[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < udt_pkg::NUM_STAGES; k++) begin
            if (adv[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load = adv[udt_pkg::NUM_STAGES-1:0];
    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[udt_pkg::STG_LAST];

    // Seconds to day number and seconds of day.
    udt_split u_split (
        .aclk          (aclk),
        .ctl           (ctl),
        .epoch_seconds (s_tdata[udt_pkg::SECS_W-1:0]),
        .jdn           (jdn),
        .sod           (sod)
    );

    // Day number to calendar date.
    udt_date u_date (
        .aclk         (aclk),
        .ctl          (ctl),
        .jdn          (jdn),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month)
    );

    // Seconds of day to hour, minute and second.
    udt_clock u_clock (
        .aclk   (aclk),
        .ctl    (ctl),
        .sod    (sod),
        .hour   (hour),
        .minute (minute),
        .second (second)
    );

    assign m_tdata = {second, minute, hour, day_of_month, month, year};

    // An accepted request always occupies the first stage next cycle.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[udt_pkg::STG_IN])
        else $error("accepted request did not enter the pipeline");

    // A result waiting behind a stalled output is held, not overwritten.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[udt_pkg::STG_LAST-1] && m_tvalid && !m_tready
        |=> valid_reg[udt_pkg::STG_LAST-1])
        else $error("request behind a stalled result was lost");

    // Calendar fields stay in range.
    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> month >= 4'd1 && month <= 4'd12
                  && day_of_month >= 5'd1 && day_of_month <= 5'd31)
        else $error("month or day of month out of range");

    // Time fields stay in range.
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
        else $error("time of day out of range");

endmodule

`default_nettype wire
